@@ rtl/core/ffra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and field widths for the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int OPCODE_W   = 2;
    localparam int SIZE_W     = 8;
    localparam int SLOT_ID_W  = 4;
    localparam int STATUS_W   = 3;
    localparam int START_W    = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_MEMORY  = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NO_PROCESS = 3'd3,
        ST_BAD_SIZE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_MARK,
        S_SLOT_RD,
        S_RELEASE,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/ffra_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_if
// Request and response channels of the region allocator (valid/ready).
// ----------------------------------------------------------------------------
interface ffra_req_if;
    import ffra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [SIZE_W-1:0]    request_size;
    logic [SLOT_ID_W-1:0] slot_id;

    modport source (output valid, output opcode, output request_size, output slot_id,
                    input ready);
    modport sink   (input valid, input opcode, input request_size, input slot_id,
                    output ready);
endinterface

interface ffra_rsp_if;
    import ffra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_ID_W-1:0] granted_slot;
    logic [START_W-1:0]   region_start;
    logic [SIZE_W-1:0]    region_size;

    modport source (output valid, output status, output granted_slot,
                    output region_start, output region_size, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input region_start, input region_size, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ffra_unit_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_unit_map
// Used-bit memory of the allocation units: one write port, one registered
// read port.
// ----------------------------------------------------------------------------
module ffra_unit_map #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic              wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic                   rdata
);

    logic used_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            used_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= used_mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/first_fit_region_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// Contiguous first-fit allocator over a unit used-bit map with a small
// process slot table: allocate, free and query one word at a time.
// ----------------------------------------------------------------------------
//  channel  dir  word fields
//  req      in   opcode, request_size, slot_id
//  rsp      out  status, granted_slot, region_start, region_size
//
//  after reset the unit map is swept clear, unit by unit, with req.ready low
//  allocate: a slot search over the table, then a map scan (one unit a cycle
//  on the map read port), then marking of size units; free reads the slot
//  entry and then clears its units, query only reads it; rejects go to S_DONE
//  one word in flight; the result is held in registers until rsp.ready,
//  and req.ready rises again the cycle after it is taken
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
    parameter int MEM_UNITS = 128,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ffra_req_if.sink    req,
    ffra_rsp_if.source  rsp
);
    import ffra_pkg::*;

    localparam int UNIT_W  = $clog2(MEM_UNITS);
    localparam int CNT_W   = $clog2(MEM_UNITS + 1);
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CMP_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int SCMP_W  = (SLOT_W + 1 > SLOT_ID_W) ? SLOT_W + 1 : SLOT_ID_W;
    localparam int ENTRY_W = UNIT_W + CNT_W;

    state_t state_reg, state_next;

    logic [OPCODE_W-1:0]  op_reg, op_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [SLOT_W-1:0]    slot_idx_reg, slot_idx_next;
    logic [CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 pend_reg, pend_next;
    logic [UNIT_W-1:0]    pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [UNIT_W-1:0]    mark_addr_reg, mark_addr_next;
    logic [UNIT_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [MAX_SLOTS-1:0] used_reg, used_next;

    status_t              res_status_reg, res_status_next;
    logic [SLOT_ID_W-1:0] res_slot_reg, res_slot_next;
    logic [START_W-1:0]   res_start_reg, res_start_next;
    logic [SIZE_W-1:0]    res_size_reg, res_size_next;

    // unit map ports
    logic              map_we;
    logic [UNIT_W-1:0] map_waddr;
    logic              map_wdata;
    logic [UNIT_W-1:0] map_raddr;
    logic              map_rdata;

    // slot table memory: {start, size}
    logic [ENTRY_W-1:0] slot_mem [MAX_SLOTS];
    logic               slot_we;
    logic [ENTRY_W-1:0] slot_wdata;
    logic               slot_re;
    logic [SLOT_W-1:0]  slot_raddr;
    logic [ENTRY_W-1:0] slot_rdata_reg;
    logic [UNIT_W-1:0]  rd_start;
    logic [CNT_W-1:0]   rd_size;

    logic             accept;
    logic             bad_size;
    logic             slot_absent;
    logic             slot_idle;
    logic             slot_free_here;
    logic             slot_last;
    logic [CNT_W-1:0] run_inc;
    logic             hit;
    logic             scan_last;
    logic [CNT_W-1:0] hit_start;

    ffra_unit_map #(
        .DEPTH  (MEM_UNITS),
        .ADDR_W (UNIT_W)
    ) u_unit_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign accept      = req.valid && (state_reg == S_IDLE);
    assign bad_size    = (req.request_size == '0)
                      || (CMP_W'(req.request_size) > CMP_W'(MEM_UNITS));
    assign slot_absent = SCMP_W'(req.slot_id) >= SCMP_W'(MAX_SLOTS);
    assign slot_idle   = slot_absent || !used_reg[SLOT_W'(req.slot_id)];

    assign slot_free_here = !used_reg[slot_idx_reg];
    assign slot_last      = slot_idx_reg == SLOT_W'(MAX_SLOTS - 1);

    // run evaluation on the unit read back this cycle
    assign run_inc   = run_reg + CNT_W'(1);
    assign hit       = pend_reg && !map_rdata && (CMP_W'(run_inc) == CMP_W'(size_reg));
    assign scan_last = pend_reg && (pend_addr_reg == UNIT_W'(MEM_UNITS - 1));
    assign hit_start = CNT_W'(pend_addr_reg) + CNT_W'(1) - CNT_W'(size_reg);

    assign rd_start = slot_rdata_reg[ENTRY_W-1:CNT_W];
    assign rd_size  = slot_rdata_reg[CNT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (scan_addr_reg == CNT_W'(MEM_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.opcode)
                        OP_ALLOC: state_next = bad_size ? S_DONE : S_FIND;
                        OP_FREE,
                        OP_QUERY: state_next = slot_idle ? S_DONE : S_SLOT_RD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_FIND:
            begin
                if (slot_free_here)
                begin
                    state_next = S_SCAN;
                end
                else if (slot_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_MARK;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_SLOT_RD:
            begin
                state_next = (op_reg == OP_FREE) ? S_RELEASE : S_DONE;
            end
            S_RELEASE:
            begin
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        op_next         = op_reg;
        size_next       = size_reg;
        slot_idx_next   = slot_idx_reg;
        scan_addr_next  = scan_addr_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        run_next        = run_reg;
        mark_addr_next  = mark_addr_reg;
        base_next       = base_reg;
        rem_next        = rem_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_start_next  = res_start_reg;
        res_size_next   = res_size_reg;

        map_we     = 1'b0;
        map_waddr  = mark_addr_reg;
        map_wdata  = 1'b0;
        map_raddr  = scan_addr_reg[UNIT_W-1:0];
        slot_we    = 1'b0;
        slot_wdata = {base_reg, CNT_W'(size_reg)};
        slot_re    = 1'b0;
        slot_raddr = SLOT_W'(req.slot_id);

        case (state_reg)
            S_CLEAR:
            begin
                map_we         = 1'b1;
                map_waddr      = scan_addr_reg[UNIT_W-1:0];
                scan_addr_next = scan_addr_reg + CNT_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.opcode;
                    size_next       = req.request_size;
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                    res_start_next  = '0;
                    res_size_next   = '0;
                    case (req.opcode)
                        OP_ALLOC:
                        begin
                            slot_idx_next = '0;
                            if (bad_size)
                            begin
                                res_status_next = ST_BAD_SIZE;
                            end
                        end
                        OP_FREE,
                        OP_QUERY:
                        begin
                            slot_idx_next = SLOT_W'(req.slot_id);
                            res_slot_next = req.slot_id;
                            if (slot_idle)
                            begin
                                res_status_next = ST_NO_PROCESS;
                            end
                            else
                            begin
                                slot_re = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (slot_free_here)
                begin
                    scan_addr_next = '0;
                    run_next       = '0;
                end
                else if (slot_last)
                begin
                    res_status_next = ST_TABLE_FULL;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + SLOT_W'(1);
                end
            end
            S_SCAN:
            begin
                // issue one unit read a cycle, judge the one read last cycle
                if (scan_addr_reg < CNT_W'(MEM_UNITS))
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = scan_addr_reg[UNIT_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    run_next = map_rdata ? '0 : run_inc;
                end
                if (hit)
                begin
                    mark_addr_next  = hit_start[UNIT_W-1:0];
                    base_next       = hit_start[UNIT_W-1:0];
                    rem_next        = CNT_W'(size_reg);
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_ID_W'(slot_idx_reg);
                    res_start_next  = START_W'(hit_start);
                    res_size_next   = size_reg;
                end
                else if (scan_last)
                begin
                    res_status_next = ST_NO_MEMORY;
                end
            end
            S_MARK:
            begin
                map_we         = 1'b1;
                map_wdata      = 1'b1;
                mark_addr_next = mark_addr_reg + UNIT_W'(1);
                rem_next       = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    slot_we                 = 1'b1;
                    used_next[slot_idx_reg] = 1'b1;
                end
            end
            S_SLOT_RD:
            begin
                res_status_next = ST_OK;
                res_start_next  = START_W'(rd_start);
                res_size_next   = SIZE_W'(rd_size);
                if (op_reg == OP_FREE)
                begin
                    mark_addr_next          = rd_start;
                    rem_next                = rd_size;
                    used_next[slot_idx_reg] = 1'b0;
                end
            end
            S_RELEASE:
            begin
                map_we         = 1'b1;
                map_wdata      = 1'b0;
                mark_addr_next = mark_addr_reg + UNIT_W'(1);
                rem_next       = rem_reg - CNT_W'(1);
            end
            S_DONE:
            begin
                map_we = 1'b0;
            end
            default:
            begin
                map_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        slot_idx_reg   <= slot_idx_next;
        pend_addr_reg  <= pend_addr_next;
        run_reg        <= run_next;
        mark_addr_reg  <= mark_addr_next;
        base_reg       <= base_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_start_reg  <= res_start_next;
        res_size_reg   <= res_size_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_idx_reg] <= slot_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_raddr];
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_DONE);
    assign rsp.status       = res_status_reg;
    assign rsp.granted_slot = res_slot_reg;
    assign rsp.region_start = res_start_reg;
    assign rsp.region_size  = res_size_reg;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate, free and query words into the first-fit region allocator
// and checks each response against a typed answer or a behavioral model of the unit map and
// slot table, under random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_top;
    import ffra_pkg::*;

    localparam int MEM_UNITS    = 128;
    localparam int MAX_SLOTS    = 16;
    localparam int DIR_ROWS     = 26;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int IDLE_LIMIT   = 5000;

    typedef struct packed {
        opcode_t              op;
        logic [SIZE_W-1:0]    size;
        logic [SLOT_ID_W-1:0] slot;
    } alloc_cmd_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_ID_W-1:0] slot;
        logic [START_W-1:0]   start;
        logic [SIZE_W-1:0]    size;
    } alloc_reply_t;

    typedef struct packed {
        alloc_cmd_t   cmd;
        bit           typed;
        alloc_reply_t want;
    } probe_row_t;

    logic clk;
    logic rst_n;

    ffra_req_if req_ch ();
    ffra_rsp_if rsp_ch ();

    first_fit_region_allocator #(
        .MEM_UNITS (MEM_UNITS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model state: used bit per unit, region per slot
    bit   [MEM_UNITS-1:0] unit_busy = '0;
    logic [SIZE_W-1:0]    held_size  [MAX_SLOTS] = '{default: '0};
    logic [START_W-1:0]   held_start [MAX_SLOTS];

    alloc_reply_t pending_replies [$];
    int           words_in     = 0;
    int           replies_seen = 0;
    int           errors       = 0;
    int           idle_cycles  = 0;

    // rows typed with an answer are checked against it, the rest against the model
    probe_row_t directed_rows [DIR_ROWS] = '{
        '{'{OP_FREE,  8'd0,   4'd15}, 1'b1, '{ST_NO_PROCESS, 4'd15, 7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd0,   4'd0},  1'b1, '{ST_BAD_SIZE,   4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd129, 4'd0},  1'b1, '{ST_BAD_SIZE,   4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd255, 4'd7},  1'b1, '{ST_BAD_SIZE,   4'd0,  7'd0, 8'd0}},
        '{'{OP_NONE,  8'h55,  4'd10}, 1'b1, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd128, 4'd0},  1'b1, '{ST_OK,         4'd0,  7'd0, 8'd128}},
        '{'{OP_ALLOC, 8'd1,   4'd0},  1'b1, '{ST_NO_MEMORY,  4'd0,  7'd0, 8'd0}},
        '{'{OP_QUERY, 8'd0,   4'd0},  1'b1, '{ST_OK,         4'd0,  7'd0, 8'd128}},
        '{'{OP_FREE,  8'd0,   4'd0},  1'b1, '{ST_OK,         4'd0,  7'd0, 8'd128}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        '{'{OP_ALLOC, 8'd8,   4'd0},  1'b0, '{ST_OK,         4'd0,  7'd0, 8'd0}},
        // memory and table both full: the table check wins
        '{'{OP_ALLOC, 8'd1,   4'd0},  1'b1, '{ST_TABLE_FULL, 4'd0,  7'd0, 8'd0}}
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic alloc_reply_t apply_region_op(input alloc_cmd_t c);
        alloc_reply_t r;
        int           slot;
        int           run;
        int           first;
        int           i;
        bit           found;
        r     = '0;
        slot  = -1;
        run   = 0;
        first = 0;
        found = 1'b0;
        case (c.op)
            OP_ALLOC:
            begin
                if (c.size == 0 || c.size > MEM_UNITS)
                    r.status = ST_BAD_SIZE;
                else
                begin
                    for (i = 0; i < MAX_SLOTS; i++)
                        if (slot < 0 && held_size[i] == 0)
                            slot = i;
                    if (slot < 0)
                        r.status = ST_TABLE_FULL;
                    else
                    begin
                        for (i = 0; i < MEM_UNITS; i++)
                        begin
                            if (!found)
                            begin
                                if (unit_busy[i])
                                    run = 0;
                                else
                                begin
                                    run++;
                                    if (run == c.size)
                                    begin
                                        found = 1'b1;
                                        first = i + 1 - c.size;
                                    end
                                end
                            end
                        end
                        if (!found)
                            r.status = ST_NO_MEMORY;
                        else
                        begin
                            for (i = first; i < first + c.size; i++)
                                unit_busy[i] = 1'b1;
                            held_start[slot] = START_W'(first);
                            held_size[slot]  = c.size;
                            r.status = ST_OK;
                            r.slot   = SLOT_ID_W'(slot);
                            r.start  = START_W'(first);
                            r.size   = c.size;
                        end
                    end
                end
            end
            OP_FREE, OP_QUERY:
            begin
                r.slot = c.slot;
                if (held_size[c.slot] == 0)
                    r.status = ST_NO_PROCESS;
                else
                begin
                    r.status = ST_OK;
                    r.start  = held_start[c.slot];
                    r.size   = held_size[c.slot];
                    if (c.op == OP_FREE)
                    begin
                        for (i = held_start[c.slot]; i < held_start[c.slot] + held_size[c.slot];
                             i++)
                            unit_busy[i] = 1'b0;
                        held_size[c.slot] = '0;
                    end
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic alloc_cmd_t random_cmd();
        alloc_cmd_t c;
        int         pick;
        c.slot = SLOT_ID_W'($urandom_range(0, MAX_SLOTS - 1));
        pick   = $urandom_range(0, 99);
        if (pick < 45)
            c.op = OP_ALLOC;
        else if (pick < 80)
            c.op = OP_FREE;
        else if (pick < 95)
            c.op = OP_QUERY;
        else
            c.op = OP_NONE;
        // sizes mostly small so the table and map churn, a few large or illegal
        pick = $urandom_range(0, 99);
        if (pick < 70)
            c.size = SIZE_W'($urandom_range(1, 16));
        else if (pick < 90)
            c.size = SIZE_W'($urandom_range(17, MEM_UNITS));
        else
            c.size = SIZE_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int random_gap(input int long_lo, input int long_hi);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(long_lo, long_hi);
    endfunction

    // called on a falling edge, returns on the falling edge after the word is taken
    task automatic send_word(input alloc_cmd_t c, input int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= c.op;
        req_ch.request_size <= c.size;
        req_ch.slot_id      <= c.slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        alloc_cmd_t   c;
        alloc_reply_t want;
        alloc_reply_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                c.op   = opcode_t'(req_ch.opcode);
                c.size = req_ch.request_size;
                c.slot = req_ch.slot_id;
                want   = apply_region_op(c);
                if (words_in < DIR_ROWS && directed_rows[words_in].typed)
                    want = directed_rows[words_in].want;
                pending_replies.push_back(want);
                words_in++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = status_t'(rsp_ch.status);
                got.slot   = rsp_ch.granted_slot;
                got.start  = rsp_ch.region_start;
                got.size   = rsp_ch.region_size;
                replies_seen++;
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual status %0d",
                             $time, got.status);
                    errors++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("granted_slot", want.slot, got.slot);
                    check_field("region_start", want.start, got.start);
                    check_field("region_size", want.size, got.size);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : rsp_sink
        int  run;
        int  gap;
        bit  held;
        held         = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // one long stall while words keep coming, so the request side backs up
            if (!held && replies_seen >= 300)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(negedge clk);
            gap = random_gap(20, 80);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin : req_source
        int i;
        int gap;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_NONE;
        req_ch.request_size = '0;
        req_ch.slot_id      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_word(directed_rows[i].cmd, random_gap(8, 40));

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            // a stretch of back-to-back words every so often
            gap = ((i % 250) < 50) ? 0 : random_gap(8, 60);
            send_word(random_cmd(), gap);
        end
        req_ch.valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
